// ===== hdl/cc20_pkg.sv =====
// ============================================================================
// cc20_pkg
// Types, constants and helpers shared by the ChaCha20 stream cipher unit.
// ============================================================================
`default_nettype none

package cc20_pkg;

    // Half quarter-round steps per block: 20 rounds, two steps each
    localparam int unsigned HALF_STEPS = 40;
    localparam logic [5:0]  LAST_STEP  = 6'(HALF_STEPS - 1);
    localparam logic [3:0]  FULL_COUNT = 4'd8;

    localparam logic [31:0] SIGMA [4] = '{
        32'h61707865, 32'h3320646E, 32'h79622D32, 32'h6B206574
    };

    // Word indexes packed as {d, c, b, a}; first four are the column round,
    // last four the diagonal round
    localparam logic [15:0] QUARTER_INDEX [8] = '{
        16'hC840, 16'hD951, 16'hEA62, 16'hFB73,
        16'hFA50, 16'hCB61, 16'hD872, 16'hE943
    };

    typedef enum logic [2:0] {
        REG_KEY_0_7     = 3'd0,
        REG_KEY_8_15    = 3'd1,
        REG_KEY_16_23   = 3'd2,
        REG_KEY_24_31   = 3'd3,
        REG_NONCE_0_7   = 3'd4,
        REG_NONCE_8_11  = 3'd5,
        REG_INIT_COUNT  = 3'd6
    } cc20_reg_t;

    typedef struct packed {
        logic [63:0] key_bytes_0_to_7;
        logic [63:0] key_bytes_8_to_15;
        logic [63:0] key_bytes_16_to_23;
        logic [63:0] key_bytes_24_to_31;
        logic [63:0] nonce_bytes_0_to_7;
        logic [31:0] nonce_bytes_8_to_11;
        logic [31:0] initial_block_count;
    } cc20_cfg_t;

    // One classified request on its way from front to back
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic [2:0]  pos;
        logic        new_block;
        logic        reload;
    } cc20_item_t;

    function automatic logic [63:0] byte_mask(input logic [3:0] count);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            m[8*i +: 8] = (4'(i) < count) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cc20_in_if.sv =====
// ============================================================================
// cc20_in_if
// Input request channel: data bytes, byte count and first-of-message flag.
// ============================================================================
`default_nettype none

interface cc20_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_in;
    logic [3:0]  byte_count;
    logic        first_of_message;

    modport source (output valid, data_in, byte_count, first_of_message, input ready);
    modport sink   (input valid, data_in, byte_count, first_of_message, output ready);
endinterface

`default_nettype wire

// ===== hdl/cc20_out_if.sv =====
// ============================================================================
// cc20_out_if
// Result channel: processed data bytes and their count.
// ============================================================================
`default_nettype none

interface cc20_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_out;
    logic [3:0]  byte_count_out;

    modport source (output valid, data_out, byte_count_out, input ready);
    modport sink   (input valid, data_out, byte_count_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/cc20_cfg_if.sv =====
// ============================================================================
// cc20_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
`default_nettype none

interface cc20_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/cc20_front.sv =====
// ============================================================================
// cc20_front
// Accepts input requests, saturates the count and tracks the keystream word
// position, tagging each request that starts a new keystream block.
// ============================================================================
`default_nettype none

module cc20_front
    import cc20_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    cc20_in_if.sink     in_chan,
    input  wire logic   q_ready,
    output logic        push,
    output cc20_item_t  item
);

    logic [2:0] pos_reg, pos_next;
    logic [3:0] count_sat;
    logic [2:0] pos_cur;

    assign in_chan.ready = q_ready;
    assign push          = in_chan.valid && q_ready;

    always_comb
    begin
        count_sat = (in_chan.byte_count > FULL_COUNT) ? FULL_COUNT : in_chan.byte_count;
        pos_cur   = in_chan.first_of_message ? 3'd0 : pos_reg;

        item.data      = in_chan.data_in;
        item.count     = count_sat;
        item.pos       = pos_cur;
        item.new_block = (pos_cur == 3'd0);
        item.reload    = in_chan.first_of_message;

        pos_next = pos_reg;
        if (push)
        begin
            // a short request ends the message: next one starts a fresh block
            pos_next = (count_sat < FULL_COUNT) ? 3'd0 : pos_cur + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cc20_queue.sv =====
// ============================================================================
// cc20_queue
// Short FIFO of classified requests between the front and the back.
// ============================================================================
`default_nettype none

module cc20_queue
    import cc20_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire cc20_item_t push_item,
    output logic            ready,
    output logic            valid,
    output cc20_item_t      head,
    input  wire logic       pop
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cc20_item_t     slot_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  fill_reg, fill_next;

    assign ready = (fill_reg != CW'(DEPTH));
    assign valid = (fill_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cc20_back.sv =====
// ============================================================================
// cc20_back
// Keystream engine: iterates the ChaCha20 rounds, applies the feed-forward
// add and XORs each request with its keystream word into the output register.
// ============================================================================
`default_nettype none

module cc20_back
    import cc20_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cc20_cfg_t  cfg,
    input  wire logic       q_valid,
    input  wire cc20_item_t q_item,
    output logic            q_pop,
    cc20_out_if.source      out_chan
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_FEED  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] work_reg [16];
    logic [31:0] work_next [16];
    logic [5:0]  step_reg, step_next;
    logic [31:0] ctr_reg, ctr_next;
    logic [31:0] used_reg, used_next;
    logic [63:0] hold_data_reg, hold_data_next;
    logic [3:0]  hold_count_reg, hold_count_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg, out_data_next;
    logic [3:0]  out_count_reg, out_count_next;

    logic [31:0] init_feed [16];
    logic [31:0] init_load [16];
    logic [31:0] round_words [16];
    logic [31:0] load_ctr;
    logic [63:0] ks_pos, ks_first;
    logic        out_free;

    assign out_chan.valid          = out_valid_reg;
    assign out_chan.data_out       = out_data_reg;
    assign out_chan.byte_count_out = out_count_reg;

    assign out_free = !out_valid_reg || out_chan.ready;
    assign load_ctr = q_item.reload ? cfg.initial_block_count : ctr_reg;
    assign ks_pos   = {work_reg[{q_item.pos, 1'b1}], work_reg[{q_item.pos, 1'b0}]};
    assign ks_first = {work_reg[1], work_reg[0]};

    // Initial state words; word 12 is the block counter
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            init_feed[i] = SIGMA[i];
        end
        init_feed[4]  = cfg.key_bytes_0_to_7[31:0];
        init_feed[5]  = cfg.key_bytes_0_to_7[63:32];
        init_feed[6]  = cfg.key_bytes_8_to_15[31:0];
        init_feed[7]  = cfg.key_bytes_8_to_15[63:32];
        init_feed[8]  = cfg.key_bytes_16_to_23[31:0];
        init_feed[9]  = cfg.key_bytes_16_to_23[63:32];
        init_feed[10] = cfg.key_bytes_24_to_31[31:0];
        init_feed[11] = cfg.key_bytes_24_to_31[63:32];
        init_feed[12] = used_reg;
        init_feed[13] = cfg.nonce_bytes_0_to_7[31:0];
        init_feed[14] = cfg.nonce_bytes_0_to_7[63:32];
        init_feed[15] = cfg.nonce_bytes_8_to_11;
        init_load     = init_feed;
        init_load[12] = load_ctr;
    end

    // One half quarter-round on all four lanes; step bit 1 picks the
    // diagonal round, step bit 0 the second half
    always_comb
    begin
        logic [15:0] q;
        logic [3:0]  ia, ib, ic, id;
        logic [31:0] va, vb, vc, vd;
        round_words = work_reg;
        for (int j = 0; j < 4; j++)
        begin
            q  = QUARTER_INDEX[{step_reg[1], 2'(j)}];
            ia = q[3:0];
            ib = q[7:4];
            ic = q[11:8];
            id = q[15:12];
            va = work_reg[ia];
            vb = work_reg[ib];
            vc = work_reg[ic];
            vd = work_reg[id];
            if (!step_reg[0])
            begin
                va = va + vb;
                vd = rotl32(vd ^ va, 16);
                vc = vc + vd;
                vb = rotl32(vb ^ vc, 12);
            end
            else
            begin
                va = va + vb;
                vd = rotl32(vd ^ va, 8);
                vc = vc + vd;
                vb = rotl32(vb ^ vc, 7);
            end
            round_words[ia] = va;
            round_words[ib] = vb;
            round_words[ic] = vc;
            round_words[id] = vd;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        work_next       = work_reg;
        step_next       = step_reg;
        ctr_next        = ctr_reg;
        used_next       = used_reg;
        hold_data_next  = hold_data_reg;
        hold_count_next = hold_count_reg;
        out_valid_next  = out_valid_reg && !out_chan.ready;
        out_data_next   = out_data_reg;
        out_count_next  = out_count_reg;
        q_pop           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.new_block)
                    begin
                        // take the request and start a block; emit it later
                        q_pop           = 1'b1;
                        used_next       = load_ctr;
                        ctr_next        = load_ctr + 32'd1;
                        work_next       = init_load;
                        step_next       = '0;
                        hold_data_next  = q_item.data;
                        hold_count_next = q_item.count;
                        state_next      = ST_ROUND;
                    end
                    else if (out_free)
                    begin
                        q_pop          = 1'b1;
                        out_valid_next = 1'b1;
                        out_data_next  = (q_item.data ^ ks_pos) & byte_mask(q_item.count);
                        out_count_next = q_item.count;
                    end
                end
            end
            ST_ROUND:
            begin
                work_next = round_words;
                step_next = step_reg + 6'd1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_FEED;
                end
            end
            ST_FEED:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    work_next[i] = work_reg[i] + init_feed[i];
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = (hold_data_reg ^ ks_first) & byte_mask(hold_count_reg);
                    out_count_next = hold_count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctr_reg       <= ctr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg       <= work_next;
        step_reg       <= step_next;
        used_reg       <= used_next;
        hold_data_reg  <= hold_data_next;
        hold_count_reg <= hold_count_next;
        out_data_reg   <= out_data_next;
        out_count_reg  <= out_count_next;
    end

`ifndef SYNTHESIS
    a_pos_zero_starts_block: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_item.new_block) |-> (q_item.pos != 3'd0))
        else $error("request at word zero without a new block");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (step_reg <= LAST_STEP))
        else $error("round step past the last step");

    a_feed_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && step_reg == LAST_STEP) |=> (state_reg == ST_FEED))
        else $error("feed-forward does not follow the last round step");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_count_reg <= FULL_COUNT))
        else $error("result byte count above eight");
`endif

endmodule

`default_nettype wire

// ===== hdl/chacha20_stream_cipher_unit.sv =====
// Flow: a request inside a block is XORed with its keystream word into the registered
//   output; a request that starts a new keystream block waits for its block first.
// Block sequence: pop, 40 half quarter-round steps on the shared four-lane round unit,
//   feed-forward, emit (held while the output is stalled); no request is taken meanwhile,
//   and a block serves up to eight full requests.
// Reset: rst_n (async, active low) clears config, counter, position, queue, output valid.
// ============================================================================
// chacha20_stream_cipher_unit
// ChaCha20 (96-bit nonce) stream cipher: front classifies requests, a short
// queue decouples it from the round engine that produces the results.
// ============================================================================
`default_nettype none

module chacha20_stream_cipher_unit
    import cc20_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    cc20_in_if.sink     in_chan,
    cc20_out_if.source  out_chan,
    cc20_cfg_if.sink    cfg_chan
);

    cc20_cfg_t  cfg_reg, cfg_next;
    cc20_item_t front_item;
    cc20_item_t q_head;
    logic       front_push;
    logic       q_ready;
    logic       q_valid;
    logic       q_pop;

    assign cfg_chan.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_chan.valid && cfg_chan.ready)
        begin
            case (cc20_reg_t'(cfg_chan.index))
                REG_KEY_0_7:    cfg_next.key_bytes_0_to_7    = cfg_chan.data;
                REG_KEY_8_15:   cfg_next.key_bytes_8_to_15   = cfg_chan.data;
                REG_KEY_16_23:  cfg_next.key_bytes_16_to_23  = cfg_chan.data;
                REG_KEY_24_31:  cfg_next.key_bytes_24_to_31  = cfg_chan.data;
                REG_NONCE_0_7:  cfg_next.nonce_bytes_0_to_7  = cfg_chan.data;
                REG_NONCE_8_11: cfg_next.nonce_bytes_8_to_11 = cfg_chan.data[31:0];
                REG_INIT_COUNT: cfg_next.initial_block_count = cfg_chan.data[31:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cc20_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_chan (in_chan),
        .q_ready (q_ready),
        .push    (front_push),
        .item    (front_item)
    );

    cc20_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_item (front_item),
        .ready     (q_ready),
        .valid     (q_valid),
        .head      (q_head),
        .pop       (q_pop)
    );

    cc20_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_head),
        .q_pop    (q_pop),
        .out_chan (out_chan)
    );

endmodule

`default_nettype wire

// ===== dv/chacha20_stream_cipher_unit_test.sv =====
// ============================================================================
// chacha20_stream_cipher_unit_test
// Self-checking bench for the ChaCha20 stream cipher unit. A directed table
// covers counts from zero to fifteen, first-of-message reloads and the
// counter wrap. Random messages with random keys and nonces follow, checked
// against a local keystream predictor. Both sides stall at random, and the
// result side holds off once for a long stretch.
// ============================================================================

module chacha20_stream_cipher_unit_test
    import cc20_pkg::*;
();

    localparam int HOLD_OFF_CYCLES = 150;
    localparam int QUIET_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 60;
    localparam int PHASE_ITEMS     = 225;
    localparam int PHASES          = 6;
    localparam int PHASE_GAP [PHASES] = '{25, 0, 40, 15, 30, 0};
    localparam logic [3:0] WORD_BYTES = 4'd8;

    // Quarter-round word order {d, c, b, a}: four column, then four diagonal
    localparam logic [15:0] QR_ORDER [8] = '{
        16'hC840, 16'hD951, 16'hEA62, 16'hFB73,
        16'hFA50, 16'hCB61, 16'hD872, 16'hE943
    };

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
    } cipher_word_t;

    typedef struct packed {
        bit          new_setting;
        logic [63:0] data;
        logic [3:0]  count;
        bit          first;
        bit          typed;
        logic [63:0] want_data;
        logic [3:0]  want_count;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 23;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{1'b0, 64'h0000000000000000, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'hFFFFFFFFFFFFFFFF, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'h0123456789ABCDEF, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'hDEADBEEFCAFEF00D, 4'd0,  1'b0, 1'b1, 64'h0, 4'd0},
        '{1'b0, 64'h0000000000000000, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'hFFFFFFFFFFFFFFFF, 4'd15, 1'b0, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'hA5A5A5A5A5A5A5A5, 4'd9,  1'b0, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'h8000000000000001, 4'd1,  1'b0, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'h7F7F7F7F7F7F7F7F, 4'd7,  1'b1, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'hFFFFFFFFFFFFFFFF, 4'd0,  1'b1, 1'b1, 64'h0, 4'd0},
        '{1'b1, 64'h0000000000000000, 4'd8,  1'b1, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'hFFFFFFFFFFFFFFFF, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'h0000000000000000, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'hFFFFFFFFFFFFFFFF, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'h0000000000000000, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'hFFFFFFFFFFFFFFFF, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'h0000000000000000, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'hFFFFFFFFFFFFFFFF, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'h0000000000000000, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'h1122334455667788, 4'd3,  1'b0, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'h0000000000000000, 4'd8,  1'b1, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'hFFFFFFFFFFFFFFFF, 4'd8,  1'b1, 1'b0, 64'h0, 4'd0},
        '{1'b0, 64'hFEDCBA9876543210, 4'd4,  1'b0, 1'b0, 64'h0, 4'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    cc20_in_if  in_chan ();
    cc20_out_if out_chan ();
    cc20_cfg_if cfg_chan ();

    chacha20_stream_cipher_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan),
        .cfg_chan (cfg_chan)
    );

    always #1 clk = ~clk;

    // Predictor state
    cc20_cfg_t    cipher_cfg = '0;
    logic [31:0]  blk_counter = '0;
    logic [2:0]   word_pos = '0;
    logic [511:0] keystream = '0;

    cipher_word_t cipher_words_due [$];
    int  mismatch_count = 0;
    int  quiet_cycles = 0;
    int  gap_pct = 0;
    bit  hold_off_request = 1'b0;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [511:0] chacha_block(input logic [31:0] ctr);
        logic [31:0]  init [16];
        logic [31:0]  x [16];
        logic [511:0] ks;
        logic [15:0]  q;
        int a, b, c, d;
        init[0]  = 32'h61707865;
        init[1]  = 32'h3320646E;
        init[2]  = 32'h79622D32;
        init[3]  = 32'h6B206574;
        init[4]  = cipher_cfg.key_bytes_0_to_7[31:0];
        init[5]  = cipher_cfg.key_bytes_0_to_7[63:32];
        init[6]  = cipher_cfg.key_bytes_8_to_15[31:0];
        init[7]  = cipher_cfg.key_bytes_8_to_15[63:32];
        init[8]  = cipher_cfg.key_bytes_16_to_23[31:0];
        init[9]  = cipher_cfg.key_bytes_16_to_23[63:32];
        init[10] = cipher_cfg.key_bytes_24_to_31[31:0];
        init[11] = cipher_cfg.key_bytes_24_to_31[63:32];
        init[12] = ctr;
        init[13] = cipher_cfg.nonce_bytes_0_to_7[31:0];
        init[14] = cipher_cfg.nonce_bytes_0_to_7[63:32];
        init[15] = cipher_cfg.nonce_bytes_8_to_11;
        x = init;
        for (int r = 0; r < 10; r++) begin
            for (int j = 0; j < 8; j++) begin
                q = QR_ORDER[j];
                a = q[3:0];
                b = q[7:4];
                c = q[11:8];
                d = q[15:12];
                x[a] = x[a] + x[b]; x[d] = rol32(x[d] ^ x[a], 16);
                x[c] = x[c] + x[d]; x[b] = rol32(x[b] ^ x[c], 12);
                x[a] = x[a] + x[b]; x[d] = rol32(x[d] ^ x[a], 8);
                x[c] = x[c] + x[d]; x[b] = rol32(x[b] ^ x[c], 7);
            end
        end
        for (int i = 0; i < 16; i++) begin
            ks[32*i +: 32] = x[i] + init[i];
        end
        return ks;
    endfunction

    function automatic cipher_word_t cipher_predict(input logic [63:0] data,
                                                    input logic [3:0]  count,
                                                    input logic        first);
        cipher_word_t res;
        logic [3:0]   eff;
        logic [63:0]  mask;
        eff = (count > WORD_BYTES) ? WORD_BYTES : count;
        if (first) begin
            blk_counter = cipher_cfg.initial_block_count;
            word_pos = '0;
        end
        if (word_pos == 3'd0) begin
            keystream = chacha_block(blk_counter);
            blk_counter = blk_counter + 32'd1;
        end
        mask = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < eff)
                mask[8*i +: 8] = 8'hFF;
        end
        res.data = (data ^ keystream[64*word_pos +: 64]) & mask;
        res.count = eff;
        // a short request ends the message: next one starts a fresh block
        word_pos = (eff < WORD_BYTES) ? 3'd0 : word_pos + 3'd1;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch: %s got %h want %h", what, got, want);
        mismatch_count++;
    endtask

    // Leave valid high on return; the next call or the caller drops it
    task automatic send_request(input logic [63:0] data, input logic [3:0] count,
                                input logic first, input bit typed,
                                input cipher_word_t want);
        cipher_word_t got;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_chan.valid            <= 1'b1;
        in_chan.data_in          <= data;
        in_chan.byte_count       <= count;
        in_chan.first_of_message <= first;
        do @(posedge clk); while (!in_chan.ready);
        got = cipher_predict(data, count, first);
        cipher_words_due.push_back(typed ? want : got);
    endtask

    task automatic wait_idle();
        in_chan.valid <= 1'b0;
        while (cipher_words_due.size() != 0) @(posedge clk);
    endtask

    task automatic put_reg(input cc20_reg_t idx, input logic [63:0] value);
        cfg_chan.valid <= 1'b1;
        cfg_chan.index <= idx;
        cfg_chan.data  <= value;
        do @(posedge clk); while (!cfg_chan.ready);
        case (idx)
            REG_KEY_0_7:    cipher_cfg.key_bytes_0_to_7    = value;
            REG_KEY_8_15:   cipher_cfg.key_bytes_8_to_15   = value;
            REG_KEY_16_23:  cipher_cfg.key_bytes_16_to_23  = value;
            REG_KEY_24_31:  cipher_cfg.key_bytes_24_to_31  = value;
            REG_NONCE_0_7:  cipher_cfg.nonce_bytes_0_to_7  = value;
            REG_NONCE_8_11: cipher_cfg.nonce_bytes_8_to_11 = value[31:0];
            REG_INIT_COUNT: cipher_cfg.initial_block_count = value[31:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(input cc20_cfg_t s);
        put_reg(REG_KEY_0_7,    s.key_bytes_0_to_7);
        put_reg(REG_KEY_8_15,   s.key_bytes_8_to_15);
        put_reg(REG_KEY_16_23,  s.key_bytes_16_to_23);
        put_reg(REG_KEY_24_31,  s.key_bytes_24_to_31);
        put_reg(REG_NONCE_0_7,  s.nonce_bytes_0_to_7);
        put_reg(REG_NONCE_8_11, {32'h0, s.nonce_bytes_8_to_11});
        put_reg(REG_INIT_COUNT, {32'h0, s.initial_block_count});
        cfg_chan.valid <= 1'b0;
    endtask

    // Result checker
    always @(posedge clk) begin : check_results
        cipher_word_t want;
        if (rst_n && out_chan.valid && out_chan.ready) begin
            if (cipher_words_due.size() == 0) begin
                report_mismatch("result with no request pending", out_chan.data_out, '0);
            end
            else begin
                want = cipher_words_due.pop_front();
                if (out_chan.data_out !== want.data)
                    report_mismatch("data_out", out_chan.data_out, want.data);
                if (out_chan.byte_count_out !== want.count)
                    report_mismatch("byte_count_out", {60'h0, out_chan.byte_count_out},
                                    {60'h0, want.count});
            end
        end
    end

    // Watchdog: end the run after a long stretch with no handshake anywhere
    always @(posedge clk) begin
        if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)
            || (cfg_chan.valid && cfg_chan.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        out_chan.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                out_chan.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_chan.ready <= 1'b1;
            end
            else if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
                out_chan.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_chan.ready <= 1'b1;
            end
            else begin
                out_chan.ready <= 1'b1;
            end
        end
    end

    initial begin
        cc20_cfg_t    s;
        cipher_word_t none;
        int           sent;
        int           full_len;
        int           tail_count;
        bit           tail;
        bit           hold_done;
        bit           pause_done;

        none = '0;
        hold_done = 1'b0;
        pause_done = 1'b0;
        rst_n                    <= 1'b0;
        in_chan.valid            <= 1'b0;
        in_chan.data_in          <= '0;
        in_chan.byte_count       <= '0;
        in_chan.first_of_message <= 1'b0;
        cfg_chan.valid           <= 1'b0;
        cfg_chan.index           <= REG_KEY_0_7;
        cfg_chan.data            <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; the first rows run on reset values
        gap_pct = 20;
        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            if (DIRECTED[row].new_setting) begin
                wait_idle();
                load_setting('1);
            end
            send_request(DIRECTED[row].data, DIRECTED[row].count, DIRECTED[row].first,
                         DIRECTED[row].typed,
                         '{DIRECTED[row].want_data, DIRECTED[row].want_count});
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            s.key_bytes_0_to_7    = {$urandom, $urandom};
            s.key_bytes_8_to_15   = {$urandom, $urandom};
            s.key_bytes_16_to_23  = {$urandom, $urandom};
            s.key_bytes_24_to_31  = {$urandom, $urandom};
            s.nonce_bytes_0_to_7  = {$urandom, $urandom};
            s.nonce_bytes_8_to_11 = $urandom;
            s.initial_block_count = $urandom;
            if (p == 0)
                s = '0;
            else if (p == 1)
                s.initial_block_count = 32'hFFFFFFF8;
            else if (p == 4)
                s = {{5{64'hFFFFFFFFFFFFFFFF}}, 32'hFFFFFFFF, s.initial_block_count};
            load_setting(s);
            gap_pct = PHASE_GAP[p];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(99) < 12) begin
                    // noise: any count, any first flag
                    send_request({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                                 1'($urandom_range(0, 1)), 1'b0, none);
                    sent++;
                end
                else begin
                    full_len = ($urandom_range(3) == 0) ? $urandom_range(9, 24)
                                                        : $urandom_range(0, 8);
                    tail = 1'($urandom_range(0, 1));
                    tail_count = $urandom_range(0, 7);
                    if (full_len == 0 && !tail)
                        full_len = 1;
                    for (int k = 0; k < full_len; k++)
                        send_request({$urandom, $urandom}, WORD_BYTES, k == 0, 1'b0, none);
                    if (tail)
                        send_request({$urandom, $urandom}, 4'(tail_count), full_len == 0,
                                     1'b0, none);
                    sent += full_len + int'(tail);
                end
                if (p == 2 && !hold_done && sent >= 60) begin
                    hold_off_request = 1'b1;
                    hold_done = 1'b1;
                end
                if (p == 3 && !pause_done && sent >= 100) begin
                    wait_idle();
                    pause_done = 1'b1;
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
